// ===== rtl/gcc_pkg.sv =====
// ----------------------------------------------------------------------------
// gcc_pkg: shared types for the graph connectivity checker
// Operation codes and the command and status bundles between the controller
// and the datapath.
// ----------------------------------------------------------------------------
package gcc_pkg;

  // Operation carried in the low bits of each input word.
  typedef enum logic [1:0] {
    OP_CLEAR    = 2'd0,
    OP_ADD_EDGE = 2'd1,
    OP_CHECK    = 2'd2
  } op_t;

  // Source of the adjacency read address.
  typedef enum logic [1:0] {
    ADJ_SEL_A     = 2'd0,
    ADJ_SEL_B     = 2'd1,
    ADJ_SEL_STACK = 2'd2
  } adj_sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     load_item;
    logic     clear_rows;
    adj_sel_t adj_rd_sel;
    logic     adj_wr_a;
    logic     adj_wr_b;
    logic     chk_init;
    logic     pop;
    logic     latch_row;
    logic     push;
    logic     load_result;
  } gcc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    op_t  op;
    logic edge_bad;
    logic stack_empty;
    logic pending_any;
  } gcc_stat_t;

endpackage

// ===== rtl/gcc_ram.sv =====
// ----------------------------------------------------------------------------
// gcc_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; the read data is registered.
// ----------------------------------------------------------------------------
module gcc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== rtl/gcc_datapath.sv =====
// ----------------------------------------------------------------------------
// gcc_datapath: adjacency store, walk stack and visited vector
// Holds the graph rows in a RAM with one valid bit per row, runs the
// depth-first walk, one push per cycle while scanning, and builds the result.
// ----------------------------------------------------------------------------
module gcc_datapath #(
  parameter int MAX_VERTICES = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic [6:0]        cfg_wr_data,
  input  logic [1:0]        item_op,
  input  logic [5:0]        item_a,
  input  logic [5:0]        item_b,
  input  gcc_pkg::gcc_cmd_t cmd,
  output gcc_pkg::gcc_stat_t stat,
  output logic              res_connected,
  output logic              res_status
);

  import gcc_pkg::*;

  localparam int VW = $clog2(MAX_VERTICES);
  localparam int DW = $clog2(MAX_VERTICES + 1);
  localparam int CW = (DW > 7) ? DW : 7;

  logic [6:0]              vertex_count;
  op_t                     op_q;
  logic [5:0]              a_q;
  logic [5:0]              b_q;
  logic [MAX_VERTICES-1:0] row_valid;
  logic                    adj_rd_ok;
  logic [MAX_VERTICES-1:0] row_q;
  logic [MAX_VERTICES-1:0] visited;
  logic [DW-1:0]           depth;

  logic [DW-1:0]           eff_count;
  logic [MAX_VERTICES-1:0] count_mask;
  logic                    edge_bad;
  logic [VW-1:0]           a_idx;
  logic [VW-1:0]           b_idx;
  logic [DW-1:0]           depth_dec;
  logic [MAX_VERTICES-1:0] pending;
  logic [MAX_VERTICES-1:0] pick_oh;
  logic [VW-1:0]           pick_idx;
  logic                    all_visited;

  logic                    adj_wr_en;
  logic [VW-1:0]           adj_wr_addr;
  logic [MAX_VERTICES-1:0] adj_wr_data;
  logic [VW-1:0]           adj_rd_addr;
  logic [MAX_VERTICES-1:0] adj_rd_data;
  logic [MAX_VERTICES-1:0] adj_base;
  logic                    stk_wr_en;
  logic [VW-1:0]           stk_wr_addr;
  logic [VW-1:0]           stk_wr_data;
  logic [VW-1:0]           stk_rd_data;

  // Vertex count clamped to the range 1 to MAX_VERTICES.
  always_comb begin
    if (vertex_count == 7'd0) begin
      eff_count = DW'(1);
    end else if (CW'(vertex_count) > CW'(MAX_VERTICES)) begin
      eff_count = DW'(MAX_VERTICES);
    end else begin
      eff_count = DW'(vertex_count);
    end
  end

  // One bit per vertex index that lies below the clamped count.
  always_comb begin
    for (int i = 0; i < MAX_VERTICES; i++) begin
      count_mask[i] = (DW'(i) < eff_count);
    end
  end

  assign edge_bad = (CW'(a_q) >= CW'(eff_count)) || (CW'(b_q) >= CW'(eff_count));
  assign a_idx    = VW'(a_q);
  assign b_idx    = VW'(b_q);

  // Neighbors of the current vertex that are in use and not yet visited.
  assign pending = row_q & ~visited & count_mask;
  assign pick_oh = pending & (~pending + MAX_VERTICES'(1));

  // Index of the lowest pending neighbor.
  always_comb begin
    pick_idx = '0;
    for (int i = 0; i < MAX_VERTICES; i++) begin
      if (pick_oh[i]) begin
        pick_idx = pick_idx | VW'(i);
      end
    end
  end

  assign all_visited = &(visited | ~count_mask);
  assign depth_dec   = depth - DW'(1);

  // Adjacency RAM: read-modify-write of one row for each edge direction.
  assign adj_base    = adj_rd_ok ? adj_rd_data : '0;
  assign adj_wr_en   = cmd.adj_wr_a || cmd.adj_wr_b;
  assign adj_wr_addr = cmd.adj_wr_b ? b_idx : a_idx;
  assign adj_wr_data = adj_base
                     | ({{(MAX_VERTICES-1){1'b0}}, 1'b1} << (cmd.adj_wr_b ? a_idx : b_idx));

  always_comb begin
    unique case (cmd.adj_rd_sel)
      ADJ_SEL_A:     adj_rd_addr = a_idx;
      ADJ_SEL_B:     adj_rd_addr = b_idx;
      ADJ_SEL_STACK: adj_rd_addr = stk_rd_data;
      default:       adj_rd_addr = a_idx;
    endcase
  end

  gcc_ram #(
    .WIDTH (MAX_VERTICES),
    .DEPTH (MAX_VERTICES)
  ) u_adj_ram (
    .clk     (clk),
    .wr_en   (adj_wr_en),
    .wr_addr (adj_wr_addr),
    .wr_data (adj_wr_data),
    .rd_addr (adj_rd_addr),
    .rd_data (adj_rd_data)
  );

  // Walk stack: vertex 0 goes in at the start, then one neighbor per push.
  assign stk_wr_en   = cmd.chk_init || cmd.push;
  assign stk_wr_addr = cmd.chk_init ? '0 : depth[VW-1:0];
  assign stk_wr_data = cmd.chk_init ? '0 : pick_idx;

  gcc_ram #(
    .WIDTH (VW),
    .DEPTH (MAX_VERTICES)
  ) u_stack_ram (
    .clk     (clk),
    .wr_en   (stk_wr_en),
    .wr_addr (stk_wr_addr),
    .wr_data (stk_wr_data),
    .rd_addr (depth_dec[VW-1:0]),
    .rd_data (stk_rd_data)
  );

  // Control state: configuration, row valid bits and stack depth.
  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= 7'd64;
      row_valid    <= '0;
      adj_rd_ok    <= 1'b0;
      depth        <= '0;
    end else begin
      if (cfg_wr_en) begin
        vertex_count <= cfg_wr_data;
      end
      adj_rd_ok <= row_valid[adj_rd_addr];
      if (cmd.clear_rows) begin
        row_valid <= '0;
      end else if (adj_wr_en) begin
        row_valid[adj_wr_addr] <= 1'b1;
      end
      if (cmd.chk_init) begin
        depth <= DW'(1);
      end else if (cmd.pop) begin
        depth <= depth_dec;
      end else if (cmd.push) begin
        depth <= depth + DW'(1);
      end
    end
  end

  // Payload registers: item fields, current row, visited marks and result.
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      op_q <= op_t'(item_op);
      a_q  <= item_a;
      b_q  <= item_b;
    end
    if (cmd.latch_row) begin
      row_q <= adj_base;
    end
    if (cmd.chk_init) begin
      visited <= {{(MAX_VERTICES-1){1'b0}}, 1'b1};
    end else if (cmd.push) begin
      visited <= visited | pick_oh;
    end
    if (cmd.load_result) begin
      res_connected <= (op_q == OP_CHECK) && all_visited;
      res_status    <= (op_q == OP_ADD_EDGE) && edge_bad;
    end
  end

  assign stat.op          = op_q;
  assign stat.edge_bad    = edge_bad;
  assign stat.stack_empty = (depth == '0);
  assign stat.pending_any = |pending;

endmodule

// ===== rtl/gcc_ctrl.sv =====
// ----------------------------------------------------------------------------
// gcc_ctrl: sequencer for clear, edge add and connectivity walk
// Steps the datapath through each operation and owns the output valid flag.
// ----------------------------------------------------------------------------
module gcc_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  gcc_pkg::gcc_stat_t stat,
  output gcc_pkg::gcc_cmd_t  cmd
);

  import gcc_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_ADD_RD_A,
    ST_ADD_WR_A,
    ST_ADD_RD_B,
    ST_ADD_WR_B,
    ST_CHK_INIT,
    ST_CHK_POP,
    ST_CHK_ROWRD,
    ST_CHK_LATCH,
    ST_CHK_SCAN,
    ST_FINISH
  } state_t;

  state_t state;
  state_t state_next;
  logic   finish_go;

  // No word is taken while reset is held.
  assign in_ready  = (state == ST_IDLE) && !rst;
  assign finish_go = (state == ST_FINISH) && (!out_valid || out_ready);

  // Commands decoded from the current state.
  always_comb begin
    cmd             = '0;
    cmd.adj_rd_sel  = ADJ_SEL_A;
    cmd.load_item   = (state == ST_IDLE) && in_valid;
    cmd.clear_rows  = (state == ST_DISPATCH) && (stat.op == OP_CLEAR);
    cmd.adj_wr_a    = (state == ST_ADD_WR_A);
    cmd.adj_wr_b    = (state == ST_ADD_WR_B);
    cmd.chk_init    = (state == ST_CHK_INIT);
    cmd.pop         = (state == ST_CHK_POP) && !stat.stack_empty;
    cmd.latch_row   = (state == ST_CHK_LATCH);
    cmd.push        = (state == ST_CHK_SCAN) && stat.pending_any;
    cmd.load_result = finish_go;
    if (state == ST_ADD_RD_B) begin
      cmd.adj_rd_sel = ADJ_SEL_B;
    end else if (state == ST_CHK_ROWRD) begin
      cmd.adj_rd_sel = ADJ_SEL_STACK;
    end
  end

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        unique case (stat.op)
          OP_ADD_EDGE: state_next = stat.edge_bad ? ST_FINISH : ST_ADD_RD_A;
          OP_CHECK:    state_next = ST_CHK_INIT;
          default:     state_next = ST_FINISH;
        endcase
      end
      ST_ADD_RD_A:  state_next = ST_ADD_WR_A;
      ST_ADD_WR_A:  state_next = ST_ADD_RD_B;
      ST_ADD_RD_B:  state_next = ST_ADD_WR_B;
      ST_ADD_WR_B:  state_next = ST_FINISH;
      ST_CHK_INIT:  state_next = ST_CHK_POP;
      ST_CHK_POP:   state_next = stat.stack_empty ? ST_FINISH : ST_CHK_ROWRD;
      ST_CHK_ROWRD: state_next = ST_CHK_LATCH;
      ST_CHK_LATCH: state_next = ST_CHK_SCAN;
      ST_CHK_SCAN: begin
        if (!stat.pending_any) begin
          state_next = ST_CHK_POP;
        end
      end
      ST_FINISH: begin
        if (finish_go) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // State and the output valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (finish_go) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/graph_connectivity_check.sv =====
// ----------------------------------------------------------------------------
// graph_connectivity_check: connectivity test on a small undirected graph
// Sequence: clear and rejected edges go straight to the result; an edge add reads and
//   writes the row of each endpoint, and a check walks every reachable vertex.
// Throughput: one word in flight; the next word is taken the cycle after the
//   result enters the output register.
// Reset: synchronous; graph empties through the row valid bits, count is 64.
// ----------------------------------------------------------------------------
module graph_connectivity_check #(
  parameter int MAX_VERTICES = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [6:0]  cfg_wr_data,    // vertex_count
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // operation[1:0], vertex_a[7:2], vertex_b[13:8]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata    // connected[0], status[1]
);

  import gcc_pkg::*;

  gcc_cmd_t  cmd;
  gcc_stat_t stat;
  logic      res_connected;
  logic      res_status;

  // Sequencer.
  gcc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Graph storage and walk datapath.
  gcc_datapath #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .item_op       (s_axis_tdata[1:0]),
    .item_a        (s_axis_tdata[7:2]),
    .item_b        (s_axis_tdata[13:8]),
    .cmd           (cmd),
    .stat          (stat),
    .res_connected (res_connected),
    .res_status    (res_status)
  );

  // Result word, padded to a byte.
  assign m_axis_tdata = {6'd0, res_status, res_connected};

endmodule
